### design/dbt_pkg.sv
// ----------------------------------------------------------------------------
// dbt_pkg: shared types and constants of the Datalog byte tokenizer
// Token kinds, scanner modes, token record and the keyword tables.
// ----------------------------------------------------------------------------
package dbt_pkg;

  localparam int KindW = 7;
  localparam int OutW  = 32;

  localparam logic [KindW-1:0] K_WS         = 7'd0;
  localparam logic [KindW-1:0] K_NEWLINE    = 7'd1;
  localparam logic [KindW-1:0] K_HASHC      = 7'd2;
  localparam logic [KindW-1:0] K_SLASHC     = 7'd3;
  localparam logic [KindW-1:0] K_BLOCK      = 7'd4;
  localparam logic [KindW-1:0] K_IDENT      = 7'd5;
  localparam logic [KindW-1:0] K_INTEGER    = 7'd6;
  localparam logic [KindW-1:0] K_STRING     = 7'd7;
  localparam logic [KindW-1:0] K_UNDERSCORE = 7'd10;
  localparam logic [KindW-1:0] K_LPAREN     = 7'd20;
  localparam logic [KindW-1:0] K_RPAREN     = 7'd21;
  localparam logic [KindW-1:0] K_COMMA      = 7'd22;
  localparam logic [KindW-1:0] K_DOT        = 7'd23;
  localparam logic [KindW-1:0] K_COLON      = 7'd24;
  localparam logic [KindW-1:0] K_BANG       = 7'd25;
  localparam logic [KindW-1:0] K_HORN       = 7'd26;
  localparam logic [KindW-1:0] K_EQ         = 7'd27;
  localparam logic [KindW-1:0] K_NEQ        = 7'd28;
  localparam logic [KindW-1:0] K_LT         = 7'd29;
  localparam logic [KindW-1:0] K_GT         = 7'd30;
  localparam logic [KindW-1:0] K_LTE        = 7'd31;
  localparam logic [KindW-1:0] K_GTE        = 7'd32;
  localparam logic [KindW-1:0] K_PLUS       = 7'd33;
  localparam logic [KindW-1:0] K_MINUS      = 7'd34;
  localparam logic [KindW-1:0] K_STAR       = 7'd35;
  localparam logic [KindW-1:0] K_SLASH      = 7'd36;
  localparam logic [KindW-1:0] K_PERCENT    = 7'd37;
  localparam logic [KindW-1:0] K_EOF        = 7'd71;
  localparam logic [KindW-1:0] K_ERROR      = 7'd72;

  // scanner modes (plain vector codes)
  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_WS   = 4'd1;
  localparam logic [3:0] M_HASHC = 4'd2;
  localparam logic [3:0] M_SLASHC = 4'd3;
  localparam logic [3:0] M_SLASHP = 4'd4;
  localparam logic [3:0] M_BLOCK = 4'd5;
  localparam logic [3:0] M_STRING = 4'd6;
  localparam logic [3:0] M_INT  = 4'd7;
  localparam logic [3:0] M_IDENT = 4'd8;
  localparam logic [3:0] M_UNDER = 4'd9;
  localparam logic [3:0] M_DOTP = 4'd10;
  localparam logic [3:0] M_DIRECTIVE = 4'd11;
  localparam logic [3:0] M_OPP  = 4'd12;

  localparam int MaxKw = 16;          // bytes per table entry; the longest word has 11
  localparam int NumKw = 43;
  localparam int NumDir = 6;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [OutW-1:0]  offset;
    logic [OutW-1:0]  length;
    logic [OutW-1:0]  line;
    logic [OutW-1:0]  col;
    logic             trivia;
    logic             last;
  } token_t;

  typedef struct packed {
    logic [MaxKw*8-1:0] text;  // byte 0 in the low bits
    logic [4:0]         len;
    logic [KindW-1:0]   kind;
  } word_t;

  function automatic word_t mk(input string s, input logic [KindW-1:0] k);
    word_t w;
    w.text = '0;
    for (int i = 0; i < s.len(); i++) w.text[i*8 +: 8] = s[i];
    w.len  = 5'(s.len());
    w.kind = k;
    return w;
  endfunction

  localparam word_t KW [NumKw] = '{
    mk("average",15), mk("count",11), mk("max",14), mk("min",13), mk("sum",12),
    mk("AVG",15), mk("COUNT",11), mk("MAX",14), mk("MIN",13), mk("SUM",12),
    mk("True",8), mk("False",9), mk("int32",16), mk("int64",17), mk("string",18),
    mk("symbol",19), mk("band",38), mk("bor",39), mk("bxor",40), mk("bnot",41),
    mk("bshl",42), mk("bshr",43), mk("hash",44), mk("md5",45), mk("sha1",46),
    mk("sha256",47), mk("sha512",48), mk({"hmac_", "sha256"},49), mk("uuid4",50),
    mk("uuid5",51), mk("strlen",52), mk("cat",53), mk("substr",54),
    mk("contains",55), mk({"str_", "prefix"},56), mk({"str_", "suffix"},57),
    mk("str_ord",58), mk({"to_", "upper"},59), mk({"to_", "lower"},60),
    mk({"str_", "replace"},61), mk("trim",62),
    mk({"to_", "string"},63), mk({"to_", "number"},64)
  };

  localparam word_t DIR [NumDir] = '{
    mk("decl",65), mk("input",66), mk("output",67), mk("printsize",68),
    mk("plan",69), mk("query",70)
  };

  function automatic logic alpha_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return alpha_ch(c) || digit_ch(c) || c == "_";
  endfunction

endpackage

### design/datalog_byte_tokenizer_core.sv
// ----------------------------------------------------------------------------
// datalog_byte_tokenizer_core: streaming Datalog lexer
// One byte (or end marker) per beat in, up to three tokens per beat out.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata = byte_value, tuser = kind   one byte or end marker
//  m_axis    out  tdata = token fields, tlast = last_of_run
//
// An input beat is taken straight into the scanner state and the tokens it
// completes (0..3) land in a result bank in the same edge. The bank drains one
// token per cycle while m_axis_tready is high; a new beat is taken when the bank
// is empty or holds one token that is going out, so single-token traffic runs
// one byte per cycle while the output is ready; beats that make two or three tokens stall input.
// Reset (rst_ni low, async) idles the scanner, sets line and column to one
// and the offset to zero. Word buffer contents are undefined until written.
// ----------------------------------------------------------------------------
module datalog_byte_tokenizer_core #(
  parameter int MaxWordLen = 11,
  parameter int PosWidth   = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] kind: 0 byte, 1 end of source
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // kind[6:0] offset[38:7] length[70:39]
                                       // line[102:71] col[134:103] trivia[135]
  output logic         m_axis_tlast    // last_of_run
);
  import dbt_pkg::*;

  localparam logic [PosWidth-1:0] PosMax = '1;

  // scanner state
  logic [3:0]          mode_q, mode_d;
  logic [PosWidth-1:0] pos_q, pos_d, line_q, line_d, col_q, col_d;
  logic [PosWidth-1:0] soff_q, soff_d, sline_q, sline_d, scol_q, scol_d;
  logic [7:0]          wcnt_q, wcnt_d;
  logic [MaxWordLen*8-1:0] wbuf_q, wbuf_d;
  logic                star_q, star_d;
  logic [7:0]          opb_q, opb_d;

  // result bank: up to three tokens, drained from slot 0
  token_t     bank_q [3];
  token_t     bank_d [3];
  logic [1:0] cnt_q, cnt_d;

  logic       take;
  logic       kin;
  logic [7:0] b;
  logic [KindW-1:0] kw_kind, dir_kind;
  logic       dir_hit;

  assign kin = s_axis_tuser;
  assign b   = s_axis_tdata;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);
  assign take = s_axis_tvalid && s_axis_tready;

  assign m_axis_tdata = {bank_q[0].trivia, bank_q[0].col, bank_q[0].line,
                         bank_q[0].length, bank_q[0].offset, bank_q[0].kind};
  assign m_axis_tlast = bank_q[0].last;

  dbt_word_match #(.MaxWordLen(MaxWordLen)) u_match (
    .word_i   (wbuf_q),
    .count_i  (wcnt_q),
    .kw_kind_o(kw_kind),
    .dir_hit_o(dir_hit),
    .dir_kind_o(dir_kind)
  );

  function automatic logic [PosWidth-1:0] sinc(input logic [PosWidth-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [OutW-1:0] clamp(input logic [PosWidth-1:0] v);
    logic [OutW-1:0] r;
    if (PosWidth > OutW) begin
      r = (v > PosWidth'({OutW{1'b1}})) ? '1 : OutW'(v);
    end else begin
      r = OutW'(v);
    end
    return r;
  endfunction

  function automatic token_t mk_tok(input logic [KindW-1:0] k,
                                    input logic [PosWidth-1:0] off,
                                    input logic [PosWidth-1:0] fin,
                                    input logic [PosWidth-1:0] ln,
                                    input logic [PosWidth-1:0] cl);
    token_t t;
    t.kind   = k;
    t.offset = clamp(off);
    t.length = clamp(fin >= off ? fin - off : '0);
    t.line   = clamp(ln);
    t.col    = clamp(cl);
    t.trivia = (k <= K_BLOCK);
    t.last   = 1'b0;
    return t;
  endfunction

  // new tokens of this beat
  token_t     nt [3];
  logic [1:0] nn;
  logic [PosWidth-1:0] endb, tail;
  logic       cont;

  always_comb begin
    mode_d = mode_q; pos_d = pos_q; line_d = line_q; col_d = col_q;
    soff_d = soff_q; sline_d = sline_q; scol_d = scol_q;
    wcnt_d = wcnt_q; wbuf_d = wbuf_q; star_d = star_q; opb_d = opb_q;
    nt[0] = '0; nt[1] = '0; nt[2] = '0;
    nn = 2'd0;
    cont = 1'b0;
    endb = sinc(pos_q);
    tail = sinc(soff_q);

    // does the pending token take the byte?
    if (!kin) begin
      unique case (mode_q) inside
        M_WS: cont = (b == " " || b == 8'h09 || b == 8'h0d);
        M_HASHC, M_SLASHC: cont = (b != 8'h0a);
        M_SLASHP: begin
          if (b == "/") begin cont = 1'b1; mode_d = M_SLASHC; end
          else if (b == "*") begin cont = 1'b1; mode_d = M_BLOCK; star_d = 1'b0; end
        end
        M_BLOCK: begin
          cont = 1'b1;
          if (star_q && b == "/") begin
            nt[0] = mk_tok(K_BLOCK, soff_q, endb, sline_q, scol_q); nn = 2'd1;
            mode_d = M_IDLE; star_d = 1'b0;
          end else star_d = (b == "*");
        end
        M_STRING: begin
          if (b == 8'h22) begin
            cont = 1'b1;
            nt[0] = mk_tok(K_STRING, soff_q, endb, sline_q, scol_q); nn = 2'd1;
            mode_d = M_IDLE;
          end else cont = (b != 8'h0a);
        end
        M_INT: cont = digit_ch(b);
        M_IDENT, M_DIRECTIVE: cont = is_word(b);
        M_UNDER: begin
          if (b == "_") cont = 1'b1;
          else if (alpha_ch(b)) begin cont = 1'b1; mode_d = M_IDENT; end
        end
        M_DOTP: begin
          if (alpha_ch(b)) begin cont = 1'b1; mode_d = M_DIRECTIVE; wcnt_d = '0; end
        end
        M_OPP: begin
          if (opb_q == ":" && b == "-") begin
            cont = 1'b1; mode_d = M_IDLE;
            nt[0] = mk_tok(K_HORN, soff_q, endb, sline_q, scol_q); nn = 2'd1;
          end else if (opb_q != ":" && b == "=") begin
            cont = 1'b1; mode_d = M_IDLE;
            nt[0] = mk_tok(opb_q == "!" ? K_NEQ : (opb_q == "<" ? K_LTE : K_GTE),
                           soff_q, endb, sline_q, scol_q);
            nn = 2'd1;
          end
        end
        default: cont = 1'b0;
      endcase
      // word bytes joining a word
      if (cont && (mode_q == M_IDENT || mode_q == M_DIRECTIVE ||
                   mode_q == M_UNDER || mode_q == M_DOTP)) begin
        for (int i = 0; i < MaxWordLen; i++)
          if (wcnt_d == 8'(i)) wbuf_d[i*8 +: 8] = b;
        if (wcnt_d != 8'hff) wcnt_d = wcnt_d + 8'd1;
      end
    end

    if (kin || !cont) begin
      // flush the pending token
      unique case (mode_q) inside
        M_WS:     begin nt[0] = mk_tok(K_WS, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_HASHC:  begin nt[0] = mk_tok(K_HASHC, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_SLASHC: begin nt[0] = mk_tok(K_SLASHC, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_SLASHP: begin nt[0] = mk_tok(K_SLASH, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_BLOCK:  begin nt[0] = mk_tok(K_BLOCK, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_STRING: begin nt[0] = mk_tok(K_ERROR, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_INT:    begin nt[0] = mk_tok(K_INTEGER, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_IDENT:  begin
          nt[0] = mk_tok((wcnt_q > 8'(MaxWordLen)) ? K_IDENT : kw_kind,
                         soff_q, pos_q, sline_q, scol_q);
          nn = 2'd1;
        end
        M_UNDER:  begin nt[0] = mk_tok(K_UNDERSCORE, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_DOTP:   begin nt[0] = mk_tok(K_DOT, soff_q, pos_q, sline_q, scol_q); nn = 2'd1; end
        M_DIRECTIVE: begin
          if (dir_hit && wcnt_q <= 8'(MaxWordLen)) begin
            nt[0] = mk_tok(dir_kind, soff_q, pos_q, sline_q, scol_q); nn = 2'd1;
          end else begin
            // directive miss: dot, then the tail as a word
            nt[0] = mk_tok(K_DOT, soff_q, tail, sline_q, scol_q);
            nt[1] = mk_tok((wcnt_q > 8'(MaxWordLen)) ? K_IDENT : kw_kind,
                           tail, pos_q, sline_q, sinc(scol_q));
            nn = 2'd2;
          end
        end
        M_OPP: begin
          nt[0] = mk_tok(opb_q == ":" ? K_COLON : (opb_q == "!" ? K_BANG :
                         (opb_q == "<" ? K_LT : K_GT)), soff_q, pos_q, sline_q, scol_q);
          nn = 2'd1;
        end
        default: nn = 2'd0;
      endcase
      mode_d = M_IDLE;

      if (kin) begin
        nt[nn] = mk_tok(K_EOF, pos_q, pos_q, line_q, col_q);
        nn = nn + 2'd1;
      end else begin
        // start a new token
        soff_d = pos_q; sline_d = line_q; scol_d = col_q;
        if (b == " " || b == 8'h09 || b == 8'h0d) mode_d = M_WS;
        else if (alpha_ch(b) || b == "_") begin
          wcnt_d = 8'd1;
          wbuf_d[7:0] = b;
          mode_d = alpha_ch(b) ? M_IDENT : M_UNDER;
        end
        else if (digit_ch(b)) mode_d = M_INT;
        else begin
          case (b) inside
            "#":   mode_d = M_HASHC;
            "/":   mode_d = M_SLASHP;
            8'h22: mode_d = M_STRING;
            ".":   mode_d = M_DOTP;
            ":", "!", "<", ">": begin opb_d = b; mode_d = M_OPP; end
            default: begin
              nt[nn] = mk_tok(b == 8'h0a ? K_NEWLINE : b == "(" ? K_LPAREN :
                              b == ")" ? K_RPAREN : b == "," ? K_COMMA :
                              b == "+" ? K_PLUS : b == "-" ? K_MINUS :
                              b == "*" ? K_STAR : b == "%" ? K_PERCENT :
                              b == "=" ? K_EQ : K_ERROR,
                              pos_q, endb, line_q, col_q);
              nn = nn + 2'd1;
            end
          endcase
        end
      end
    end

    if (!kin) begin
      pos_d = endb;
      if (b == 8'h0a) begin line_d = sinc(line_q); col_d = PosWidth'(1); end
      else col_d = sinc(col_q);
    end
    if (nn != 2'd0) nt[nn - 2'd1].last = 1'b1;
  end

  // bank update: pop one on output beat, load new tokens on input beat
  always_comb begin
    bank_d[0] = bank_q[0]; bank_d[1] = bank_q[1]; bank_d[2] = bank_q[2];
    cnt_d = cnt_q;
    if (m_axis_tvalid && m_axis_tready) begin
      bank_d[0] = bank_q[1]; bank_d[1] = bank_q[2];
      cnt_d = cnt_q - 2'd1;
    end
    if (take) begin
      // bank is empty after the pop when take is high
      bank_d[0] = nt[0]; bank_d[1] = nt[1]; bank_d[2] = nt[2];
      cnt_d = nn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      line_q <= PosWidth'(1);
      col_q  <= PosWidth'(1);
      soff_q <= '0;
      sline_q <= PosWidth'(1);
      scol_q <= PosWidth'(1);
      wcnt_q <= '0;
      star_q <= 1'b0;
      opb_q  <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        mode_q <= mode_d; pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
        soff_q <= soff_d; sline_q <= sline_d; scol_q <= scol_d;
        wcnt_q <= wcnt_d; star_q <= star_d; opb_q <= opb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) wbuf_q <= wbuf_d;
    bank_q[0] <= bank_d[0];
    bank_q[1] <= bank_d[1];
    bank_q[2] <= bank_d[2];
  end

  // assertions
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3 || !s_axis_tready)
    else $error("ready with full bank");
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
                          take && kin |=> m_axis_tvalid)
    else $error("end marker gave no token");
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
                           take && kin |=> mode_q == M_IDLE)
    else $error("scanner not idle after end marker");

endmodule

### design/dbt_word_match.sv
// ----------------------------------------------------------------------------
// dbt_word_match: parallel keyword and directive lookup
// Compares the current word buffer against both constant tables at once.
// ----------------------------------------------------------------------------
module dbt_word_match #(
  parameter int MaxWordLen = 11
) (
  input  logic [MaxWordLen*8-1:0]  word_i,
  input  logic [7:0]               count_i,
  output logic [dbt_pkg::KindW-1:0] kw_kind_o,
  output logic                     dir_hit_o,
  output logic [dbt_pkg::KindW-1:0] dir_kind_o
);
  import dbt_pkg::*;

  function automatic logic hit(input word_t e, input logic [MaxWordLen*8-1:0] w,
                               input logic [7:0] n);
    logic ok;
    ok = (e.len <= 5'(MaxWordLen)) && (8'(e.len) == n);
    for (int i = 0; i < MaxWordLen; i++)
      if (i < e.len && w[i*8 +: 8] != e.text[i*8 +: 8]) ok = 1'b0;
    return ok;
  endfunction

  always_comb begin
    kw_kind_o = K_IDENT;
    for (int i = NumKw - 1; i >= 0; i--)
      if (hit(KW[i], word_i, count_i)) kw_kind_o = KW[i].kind;
    dir_hit_o  = 1'b0;
    dir_kind_o = K_DOT;
    for (int i = NumDir - 1; i >= 0; i--)
      if (hit(DIR[i], word_i, count_i)) begin
        dir_hit_o  = 1'b1;
        dir_kind_o = DIR[i].kind;
      end
  end

endmodule

### bench/tb_datalog_byte_tokenizer_core.sv
// ----------------------------------------------------------------------------
// tb_datalog_byte_tokenizer_core: self-checking bench for the byte tokenizer
// Feeds Datalog-like source text and raw bytes, predicts every token in a
// behavioural lexer and compares each output beat field by field.
// ----------------------------------------------------------------------------
module tb_datalog_byte_tokenizer_core;
  import dbt_pkg::*;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [31:0]      offset;
    logic [31:0]      length;
    logic [31:0]      line;
    logic [31:0]      col;
    logic             trivia;
    logic             last;
  } tok_s;

  // holds the predicted tokens and matches output beats against them
  class token_board;
    tok_s pending[$];
    int   errors;
    int   seen;

    function void note(tok_s t);
      pending.push_back(t);
    endfunction

    function void check(tok_s a);
      tok_s e;
      seen++;
      if (pending.size() == 0) begin
        $error("unexpected token kind=%0d off=%0d", a.kind, a.offset);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== a.kind) begin
        $error("kind: expected %0d got %0d", e.kind, a.kind); errors++;
      end
      if (e.offset !== a.offset) begin
        $error("offset: expected %0d got %0d", e.offset, a.offset); errors++;
      end
      if (e.length !== a.length) begin
        $error("length: expected %0d got %0d", e.length, a.length); errors++;
      end
      if (e.line !== a.line) begin
        $error("line: expected %0d got %0d", e.line, a.line); errors++;
      end
      if (e.col !== a.col) begin
        $error("col: expected %0d got %0d", e.col, a.col); errors++;
      end
      if (e.trivia !== a.trivia) begin
        $error("trivia: expected %0d got %0d", e.trivia, a.trivia); errors++;
      end
      if (e.last !== a.last) begin
        $error("last: expected %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;  // [7:0] byte_value
  logic         s_axis_tuser = 1'b0; // [0] kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;       // kind, offset, length, line, col, trivia
  logic         m_axis_tlast;

  datalog_byte_tokenizer_core u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  initial forever #1 clk_i = ~clk_i;

  token_board board = new();

  // ---- lexer state mirrored in the bench ----
  logic [3:0]  lx_mode = M_IDLE;
  logic [31:0] lx_pos = 0, lx_line = 1, lx_col = 1;
  logic [31:0] st_off = 0, st_line = 1, st_col = 1;
  logic [7:0]  word_buf [16];
  int          word_n = 0;
  logic        star = 1'b0;
  logic [7:0]  op_ch = 8'd0;
  tok_s        step_toks[$];

  function automatic logic [31:0] sat1(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic is_sp(logic [7:0] c);
    return c == " " || c == "\t" || c == "\r";
  endfunction

  function automatic void put_tok(logic [KindW-1:0] k, logic [31:0] off, logic [31:0] fin,
                                  logic [31:0] ln, logic [31:0] cl);
    tok_s t;
    if (step_toks.size() >= 3) return;
    t.kind = k; t.offset = off; t.length = (fin >= off) ? fin - off : 32'd0;
    t.line = ln; t.col = cl; t.trivia = (k <= K_BLOCK); t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void put_cur(logic [KindW-1:0] k, logic [31:0] fin);
    put_tok(k, st_off, fin, st_line, st_col);
  endfunction

  function automatic void push_ch(logic [7:0] c);
    if (word_n < 11) word_buf[word_n] = c;
    if (word_n < 255) word_n++;
  endfunction

  // keyword or directive match on the buffered word; -1 on miss
  function automatic int word_match(logic use_dir);
    word_t w;
    int n;
    logic hit;
    if (word_n > 11) return -1;
    n = use_dir ? NumDir : NumKw;
    for (int i = 0; i < n; i++) begin
      w = use_dir ? DIR[i] : KW[i];
      if (w.len == word_n) begin
        hit = 1'b1;
        for (int j = 0; j < word_n; j++)
          if (w.text[j*8 +: 8] != word_buf[j]) hit = 1'b0;
        if (hit) return w.kind;
      end
    end
    return -1;
  endfunction

  function automatic logic [KindW-1:0] word_kind();
    int k;
    k = word_match(1'b0);
    return (k < 0) ? K_IDENT : KindW'(k);
  endfunction

  function automatic void flush_tok(logic [31:0] p);
    int k;
    logic [31:0] tail;
    case (lx_mode) inside
      M_WS:     put_cur(K_WS, p);
      M_HASHC:  put_cur(K_HASHC, p);
      M_SLASHC: put_cur(K_SLASHC, p);
      M_SLASHP: put_cur(K_SLASH, p);
      M_BLOCK:  put_cur(K_BLOCK, p);
      M_STRING: put_cur(K_ERROR, p);
      M_INT:    put_cur(K_INTEGER, p);
      M_IDENT:  put_cur(word_kind(), p);
      M_UNDER:  put_cur(K_UNDERSCORE, p);
      M_DOTP:   put_cur(K_DOT, p);
      M_DIRECTIVE: begin
        k = word_match(1'b1);
        if (k >= 0) put_cur(KindW'(k), p);
        else begin
          // directive miss: a dot, then the tail as a word
          tail = sat1(st_off);
          put_cur(K_DOT, tail);
          put_tok(word_kind(), tail, p, st_line, sat1(st_col));
        end
      end
      M_OPP: put_cur(op_ch == ":" ? K_COLON : op_ch == "!" ? K_BANG :
                     op_ch == "<" ? K_LT : K_GT, p);
      default: ;
    endcase
    lx_mode = M_IDLE;
  endfunction

  function automatic logic extend_tok(logic [7:0] b, logic [31:0] nx);
    case (lx_mode) inside
      M_WS: return is_sp(b);
      M_HASHC, M_SLASHC: return b != "\n";
      M_SLASHP: begin
        if (b == "/") begin lx_mode = M_SLASHC; return 1; end
        if (b == "*") begin lx_mode = M_BLOCK; star = 0; return 1; end
        return 0;
      end
      M_BLOCK: begin
        if (star && b == "/") begin
          put_cur(K_BLOCK, nx); lx_mode = M_IDLE; star = 0;
        end else star = (b == "*");
        return 1;
      end
      M_STRING: begin
        if (b == "\"") begin put_cur(K_STRING, nx); lx_mode = M_IDLE; return 1; end
        return b != "\n";
      end
      M_INT: return digit_ch(b);
      M_IDENT, M_DIRECTIVE: begin
        if (is_word(b)) begin push_ch(b); return 1; end
        return 0;
      end
      M_UNDER: begin
        if (b == "_") begin push_ch(b); return 1; end
        if (alpha_ch(b)) begin push_ch(b); lx_mode = M_IDENT; return 1; end
        return 0;
      end
      M_DOTP: begin
        if (alpha_ch(b)) begin
          word_n = 0; push_ch(b); lx_mode = M_DIRECTIVE; return 1;
        end
        return 0;
      end
      M_OPP: begin
        if (op_ch == ":" && b == "-") begin
          put_cur(K_HORN, nx); lx_mode = M_IDLE; return 1;
        end
        if (op_ch != ":" && b == "=") begin
          put_cur(op_ch == "!" ? K_NEQ : op_ch == "<" ? K_LTE : K_GTE, nx);
          lx_mode = M_IDLE; return 1;
        end
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void open_tok(logic [7:0] b, logic [31:0] nx);
    st_off = lx_pos; st_line = lx_line; st_col = lx_col;
    lx_mode = M_IDLE;
    if (is_sp(b)) lx_mode = M_WS;
    else if (alpha_ch(b)) begin word_n = 0; push_ch(b); lx_mode = M_IDENT; end
    else if (digit_ch(b)) lx_mode = M_INT;
    else case (b) inside
      "\n": put_cur(K_NEWLINE, nx);
      "#":  lx_mode = M_HASHC;
      "/":  lx_mode = M_SLASHP;
      "_":  begin word_n = 0; push_ch(b); lx_mode = M_UNDER; end
      "\"": lx_mode = M_STRING;
      ".":  lx_mode = M_DOTP;
      ":", "!", "<", ">": begin op_ch = b; lx_mode = M_OPP; end
      "(":  put_cur(K_LPAREN, nx);
      ")":  put_cur(K_RPAREN, nx);
      ",":  put_cur(K_COMMA, nx);
      "+":  put_cur(K_PLUS, nx);
      "-":  put_cur(K_MINUS, nx);
      "*":  put_cur(K_STAR, nx);
      "%":  put_cur(K_PERCENT, nx);
      "=":  put_cur(K_EQ, nx);
      default: put_cur(K_ERROR, nx);
    endcase
  endfunction

  // predict the tokens of one accepted beat and hand them to the board
  function automatic void lex_beat(logic eof, logic [7:0] b);
    logic [31:0] nx;
    step_toks.delete();
    nx = sat1(lx_pos);
    if (eof) begin
      flush_tok(lx_pos);
      put_tok(K_EOF, lx_pos, lx_pos, lx_line, lx_col);
    end else begin
      if (!extend_tok(b, nx)) begin
        flush_tok(lx_pos);
        open_tok(b, nx);
      end
      lx_pos = nx;
      if (b == "\n") begin lx_line = sat1(lx_line); lx_col = 32'd1; end
      else lx_col = sat1(lx_col);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) board.note(step_toks[i]);
  endfunction

  // ---- output side: stall pattern and checking ----
  int n_beats = 0;
  always @(posedge clk_i) begin
    tok_s a;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        a.kind   = m_axis_tdata[6:0];
        a.offset = m_axis_tdata[38:7];
        a.length = m_axis_tdata[70:39];
        a.line   = m_axis_tdata[102:71];
        a.col    = m_axis_tdata[134:103];
        a.trivia = m_axis_tdata[135];
        a.last   = m_axis_tlast;
        board.check(a);
      end
      // stall in phases: long open stretches, then bouts of random stalling
      m_axis_tready <= ((n_beats / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // ---- input side ----
  int burst_left = 0;

  task automatic send(logic eof, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    lex_beat(eof, b);
    n_beats++;
    burst_left--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(1'b0, s[i]);
  endtask

  // source fragments, some malformed, with random bytes and end markers mixed in around them
  string frags[] = '{
    "edge(X, Y) :- path(X, _Z), !done(Y).\n", ".decl edge(a: symbol, b: number)\n",
    ".printsize p\n", ".bogus x\n", "count : sum max AVG COUNT True False\n",
    "x <= 10, y >= 2, z != 3, w < 1, v > 0, q = 4 + 5 - 6 * 7 % 8\n",
    "\"a string\" \"cut\n", "# hash note\n", "// slash note\n", "/* blk ** x */ ",
    {"hmac_", "sha256 str_", "replace to_", "number verylongidentifier_x\n"},
    "__ _a _ 123 007\n",
    "a / b\t\r \n", ".input in .output out .query q .plan .x9\n"
  };

  task automatic random_item();
    int r;
    string f;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      f = frags[$urandom_range(0, frags.size()-1)];
      send_text(f);
    end else if (r < 95) send(1'b0, 8'($urandom));
    else send(1'b1, 8'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed opening: operators, extremes, unterminated cases
    send(1'b1, 8'hFF);          // end marker on an empty source
    send(1'b1, 8'h00);          // repeated end marker
    send_text(":- :x!=<=>=<a>b.");
    send(1'b0, 8'h00);          // NUL is an error byte
    send(1'b0, 8'hFF);          // high byte is an error byte
    send(1'b0, 8'h80);
    send_text("\"open");
    send(1'b1, 8'h00);          // string cut by the end
    send_text("/* open *");
    send(1'b1, 8'h55);          // block comment closed by the end
    send_text(".decl");
    send(1'b1, 8'hAA);
    while (n_beats < 330) random_item();
    send(1'b1, 8'h00);
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d input beats, %0d tokens checked across comments, strings,",
             n_beats, board.seen);
    $display("words, directives, operators, error bytes and end markers.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
design/dbt_pkg.sv
design/dbt_word_match.sv
design/datalog_byte_tokenizer_core.sv
bench/tb_datalog_byte_tokenizer_core.sv
